// ===== rtl/tihlc_pkg.sv =====
`default_nettype none

package tihlc_pkg;

  localparam int unsigned DIV_NUM_W = 16;
  localparam int unsigned DIV_DEN_W = 7;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic [15:0] TVOC_KNEE_LO = 16'd200;
  localparam logic [15:0] TVOC_KNEE_HI = 16'd800;
  localparam logic [6:0]  INDEX_MID    = 7'd60;
  localparam logic [6:0]  INDEX_MAX    = 7'd100;

  // t*60/200 as t*615 >> 11, exact for t <= 200
  localparam logic [16:0] LOW_SEG_RECIP  = 17'd615;
  localparam int unsigned LOW_SEG_SHIFT  = 11;
  // (t-200)*30/600 as (t-200)*205 >> 12, exact for t-200 <= 600
  localparam logic [16:0] HIGH_SEG_RECIP = 17'd205;
  localparam int unsigned HIGH_SEG_SHIFT = 12;
  // time/1000 by reciprocal, exact over the full 32-bit range
  localparam logic [31:0] PERIOD_MS      = 32'd1000;
  localparam logic [28:0] PERIOD_RECIP   = 29'd274877907;
  localparam int unsigned PERIOD_SHIFT   = 38;
  // 240*f/1000 as f*15732 >> 16, exact for f <= 500
  localparam logic [7:0]  BLUE_FLOOR     = 8'd20;
  localparam logic [22:0] BLUE_RECIP     = 23'd15732;
  localparam int unsigned BLUE_SHIFT     = 16;
  localparam logic [14:0] FULL_SCALE     = 15'd255;

  localparam logic [6:0]  RESET_LOW    = 7'd33;
  localparam logic [6:0]  RESET_HIGH   = 7'd66;
  localparam logic [5:0]  RESET_BAND   = 6'd5;
  localparam logic [31:0] RESET_WARMUP = 32'd30000;

  typedef enum logic [1:0] {
    CFG_THRESHOLD_LOW  = 2'd0,
    CFG_THRESHOLD_HIGH = 2'd1,
    CFG_HYSTERESIS     = 2'd2,
    CFG_WARMUP_LEN     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] tvoc_level;
    logic [31:0] time_ms;
  } sample_t;

  typedef struct packed {
    logic [6:0] air_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       warming;
  } result_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INDEX,
    S_BRANCH,
    S_PERIOD,
    S_FOLD,
    S_BLUE,
    S_COLOR,
    S_BLEND_WAIT,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/tvoc_index_hysteresis_led_color.sv =====
`default_nettype none

// TVOC air-quality index with threshold hysteresis and LED color. Each sample
// (tvoc_level, time_ms) yields one result: the 0..100 index, an RGB color and
// the warming flag. The index and the blue pulse use constant reciprocal
// multiplies; only the color blend runs on a 16-step serial divider (one
// quotient bit per cycle) under a small sequencer. sample_ready is low while
// an item is in progress. A warmup sample passes S_INDEX, S_BRANCH, S_PERIOD,
// S_FOLD and S_BLUE; after warmup it passes S_INDEX, S_BRANCH and S_COLOR,
// then S_BLEND_WAIT when the index is above the low threshold. Each item ends
// in S_FINISH; the result turns valid in the same cycle that the next sample
// can be taken. A finished result waits in an output register and the next
// sample is taken meanwhile; a second finished result waits until the first
// transfer. Configuration writes are accepted at any time but are meant for
// idle periods; unknown indexes do not exist on the two-bit index.
module tvoc_index_hysteresis_led_color (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 sample_valid,
  output logic                      sample_ready,
  input  wire tihlc_pkg::sample_t   sample,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output tihlc_pkg::result_t        result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [31:0]          cfg_data
);
  import tihlc_pkg::*;

  state_t state, state_next;

  logic [6:0]  threshold_low;
  logic [6:0]  threshold_high;
  logic [5:0]  hysteresis_band;
  logic [31:0] warmup_len;
  logic [6:0]  last_index;

  logic [15:0] tvoc;
  logic [31:0] now;
  logic [6:0]  n;
  logic        warm;
  logic [22:0] period_quot;
  logic [8:0]  tri_ms;
  logic        blend_red;
  logic [7:0]  red, green, blue;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic sample_xfer;
  logic result_load;
  logic warm_c;
  logic low_seg;
  logic n_le_lo, n_le_hi, blend_needed;
  logic [6:0]  stab;
  logic [9:0]  seg_offset;
  logic [16:0] low_prod, high_prod;
  logic [6:0]  n_c;
  logic [60:0] period_prod;
  logic [31:0] period_base;
  logic [9:0]  m_c;
  logic [9:0]  m_rest;
  logic [22:0] blue_prod;

  logic signed [8:0] ns, ps, los, his, bs, lmb, lpb, hmb, hpb;
  logic gate, inside_band, keep;

  tihlc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg_ready   = 1'b1;
  assign sample_xfer = sample_valid && sample_ready;
  assign warm_c      = now < warmup_len;
  assign low_seg     = tvoc <= TVOC_KNEE_LO;

  // piecewise index
  always_comb begin
    seg_offset = tvoc[9:0] - TVOC_KNEE_LO[9:0];
    low_prod   = 17'(tvoc[7:0]) * LOW_SEG_RECIP;
    high_prod  = 17'(seg_offset) * HIGH_SEG_RECIP;
    if (tvoc > TVOC_KNEE_HI) begin
      n_c = INDEX_MAX;
    end else if (low_seg) begin
      n_c = 7'(low_prod >> LOW_SEG_SHIFT);
    end else begin
      n_c = INDEX_MID + 7'(high_prod >> HIGH_SEG_SHIFT);
    end
  end

  // hysteresis on signed thresholds
  always_comb begin
    ns  = $signed({2'b00, n});
    ps  = $signed({2'b00, last_index});
    los = $signed({2'b00, threshold_low});
    his = $signed({2'b00, threshold_high});
    bs  = $signed({3'b000, hysteresis_band});
    lmb = los - bs;
    lpb = los + bs;
    hmb = his - bs;
    hpb = his + bs;
    gate = (ns <= lmb) ||
           (ns > lmb && ns < lpb && ps >= los) ||
           (ns > hmb && ns < hpb && ps >= his) ||
           (ns >= hpb);
    inside_band = (ns >= lmb) && (ns <= hpb);
    keep = gate && inside_band &&
           ((ps < los && ns < lpb) ||
            (ps >= los && ps < his && ns < hpb) ||
            (ps >= his && ns > hmb));
    stab = keep ? last_index : n;
  end

  assign n_le_lo      = n <= threshold_low;
  assign n_le_hi      = n <= threshold_high;
  assign blend_needed = !n_le_lo && (n_le_hi || threshold_high < INDEX_MAX);

  assign period_prod = 61'(now) * 61'(PERIOD_RECIP);
  assign period_base = 32'(period_quot) * PERIOD_MS;
  assign m_c         = 10'(now - period_base);
  assign m_rest      = PERIOD_MS[9:0] - m_c;
  assign blue_prod   = 23'(tri_ms) * BLUE_RECIP;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (sample_xfer) state_next = S_INDEX;
      S_INDEX:      state_next = S_BRANCH;
      S_BRANCH:     state_next = warm_c ? S_PERIOD : S_COLOR;
      S_PERIOD:     state_next = S_FOLD;
      S_FOLD:       state_next = S_BLUE;
      S_BLUE:       state_next = S_FINISH;
      S_COLOR:      state_next = blend_needed ? S_BLEND_WAIT : S_FINISH;
      S_BLEND_WAIT: if (div_rsp.done) state_next = S_FINISH;
      S_FINISH:     if (!result_valid || result_ready) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    sample_ready = 1'b0;
    result_load  = 1'b0;
    div_req      = '0;
    unique case (state)
      S_IDLE: sample_ready = 1'b1;
      S_COLOR: begin
        if (blend_needed) begin
          div_req.start = 1'b1;
          if (n_le_hi) begin
            div_req.num = DIV_NUM_W'(15'(n - threshold_low) * FULL_SCALE);
            div_req.den = DIV_DEN_W'(threshold_high - threshold_low);
          end else begin
            div_req.num = DIV_NUM_W'(15'(INDEX_MAX - n) * FULL_SCALE);
            div_req.den = DIV_DEN_W'(INDEX_MAX - threshold_high);
          end
        end
      end
      S_FINISH: result_load = !result_valid || result_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      result_valid    <= 1'b0;
      last_index      <= '0;
      threshold_low   <= RESET_LOW;
      threshold_high  <= RESET_HIGH;
      hysteresis_band <= RESET_BAND;
      warmup_len      <= RESET_WARMUP;
    end else begin
      state <= state_next;
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (state == S_BRANCH && !warm_c) begin
        last_index <= stab;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_THRESHOLD_LOW:  threshold_low   <= cfg_data[6:0];
          CFG_THRESHOLD_HIGH: threshold_high  <= cfg_data[6:0];
          CFG_HYSTERESIS:     hysteresis_band <= cfg_data[5:0];
          CFG_WARMUP_LEN:     warmup_len      <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (sample_xfer) begin
          tvoc <= sample.tvoc_level;
          now  <= sample.time_ms;
        end
      end
      S_INDEX: n <= n_c;
      S_BRANCH: begin
        warm  <= warm_c;
        red   <= '0;
        green <= '0;
        blue  <= '0;
        if (!warm_c) n <= stab;
      end
      S_PERIOD: period_quot <= 23'(period_prod >> PERIOD_SHIFT);
      S_FOLD:   tri_ms <= (m_c < m_rest) ? m_c[8:0] : m_rest[8:0];
      S_BLUE:   blue <= BLUE_FLOOR + 8'(blue_prod >> BLUE_SHIFT);
      S_COLOR: begin
        blend_red <= n_le_hi;
        if (n_le_lo) begin
          red   <= 8'd0;
          green <= 8'd255;
        end else if (n_le_hi) begin
          green <= 8'd255;
        end else begin
          red   <= 8'd255;
          green <= 8'd0;
        end
      end
      S_BLEND_WAIT: begin
        if (div_rsp.done) begin
          if (blend_red) red <= div_rsp.quot[7:0];
          else           green <= div_rsp.quot[7:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.air_index <= n;
      result.red       <= red;
      result.green     <= green;
      result.blue      <= blue;
      result.warming   <= warm;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tihlc_div.sv =====
`default_nettype none

module tihlc_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tihlc_pkg::div_req_t req,
  output tihlc_pkg::div_rsp_t      rsp
);
  import tihlc_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;

  logic [DIV_DEN_W:0]   trial;
  logic                 fits;
  logic [DIV_DEN_W-1:0] rem_next;

  // one restoring step per cycle
  always_comb begin
    trial    = {rem, quo[DIV_NUM_W-1]};
    fits     = trial >= {1'b0, den};
    rem_next = fits ? DIV_DEN_W'(trial - {1'b0, den}) : trial[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == {DIV_CNT_W{1'b1}}) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      quo <= {quo[DIV_NUM_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule

`default_nettype wire

// ===== tb/tvoc_index_hysteresis_led_color_tb.sv =====
`default_nettype none

module tvoc_index_hysteresis_led_color_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tihlc_pkg::*;

  localparam int N_DIRECTED = 21;
  localparam int N_PHASES = 7;
  localparam int PHASE_ITEMS = 62;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 600;
  localparam int HOLD_AT = 100;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic [15:0] tvoc;
    logic [31:0] tm;
    logic        known;
    result_t     want;
  } row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_ready;
  sample_t     sample = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor copy of the block's registers and state
  logic [6:0]  thr_lo = RESET_LOW;
  logic [6:0]  thr_hi = RESET_HIGH;
  logic [5:0]  band = RESET_BAND;
  logic [31:0] warm_len = RESET_WARMUP;
  logic [6:0]  last_idx = '0;

  result_t     color_queue[$];
  int unsigned results_seen = 0;
  int unsigned failures = 0;
  int unsigned idle_cycles = 0;
  bit          calm = 1'b0;
  logic [15:0] walk_tvoc = 16'd300;

  row_t directed [N_DIRECTED] = '{
    {16'd0,     32'd0,          1'b1, 7'd0,   8'd0,   8'd0,   8'd20,  1'b1},
    {16'd65535, 32'd500,        1'b1, 7'd100, 8'd0,   8'd0,   8'd140, 1'b1},
    {16'd800,   32'd29999,      1'b0, 32'd0},
    {16'd0,     32'd30000,      1'b1, 7'd0,   8'd0,   8'd255, 8'd0,   1'b0},
    {16'd110,   32'd30001,      1'b0, 32'd0},
    {16'd100,   32'd31000,      1'b0, 32'd0},
    {16'd90,    32'd31500,      1'b0, 32'd0},
    {16'd120,   32'd40000,      1'b0, 32'd0},
    {16'd330,   32'd40001,      1'b0, 32'd0},
    {16'd290,   32'd50000,      1'b0, 32'd0},
    {16'd260,   32'd12345,      1'b0, 32'd0},
    {16'd260,   32'd60000,      1'b0, 32'd0},
    {16'd230,   32'd60001,      1'b0, 32'd0},
    {16'd400,   32'd60002,      1'b0, 32'd0},
    {16'd420,   32'd60003,      1'b0, 32'd0},
    {16'd800,   32'd70000,      1'b0, 32'd0},
    {16'd801,   32'd70001,      1'b0, 32'd0},
    {16'd201,   32'd70002,      1'b0, 32'd0},
    {16'd200,   32'd1500,       1'b0, 32'd0},
    {16'd65535, 32'hFFFF_FFFF,  1'b1, 7'd100, 8'd255, 8'd0,   8'd0,   1'b0},
    {16'd0,     32'h8000_0000,  1'b0, 32'd0}
  };

  tvoc_index_hysteresis_led_color dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [6:0] tvoc_to_index(logic [15:0] t);
    int unsigned tv;
    tv = t;
    if (tv <= 200) return 7'(tv * 60 / 200);
    if (tv <= 800) return 7'(60 + (tv - 200) * 30 / 600);
    return 7'd100;
  endfunction

  function automatic logic [6:0] settle_index(logic [6:0] raw);
    int  n, p, lo, hi, b;
    bit  gate;
    n = raw;
    p = last_idx;
    lo = thr_lo;
    hi = thr_hi;
    b = band;
    gate = (n <= lo - b) || (n > lo - b && n < lo + b && p >= lo) ||
           (n > hi - b && n < hi + b && p >= hi) || (n >= hi + b);
    if (!gate || n < lo - b || n > hi + b) return raw;
    if (p < lo && n < lo + b) return last_idx;
    if (p >= lo && p < hi && n < hi + b) return last_idx;
    if (p >= hi && n > hi - b) return last_idx;
    return raw;
  endfunction

  function automatic logic [7:0] blend(int num, int den);
    if (den <= 0 || num < 0) return 8'd0;
    if (num > den) num = den;
    return 8'(255 * num / den);
  endfunction

  function automatic result_t predict_led(sample_t s);
    result_t     r;
    int          n, lo, hi;
    int unsigned m, fold;
    r = '0;
    r.air_index = tvoc_to_index(s.tvoc_level);
    r.warming = s.time_ms < warm_len;
    if (r.warming) begin
      m = s.time_ms % 1000;
      fold = (m < 1000 - m) ? m : 1000 - m;
      r.blue = 8'(20 + 240 * fold / 1000);
    end else begin
      r.air_index = settle_index(r.air_index);
      last_idx = r.air_index;
      n = r.air_index;
      lo = thr_lo;
      hi = thr_hi;
      if (n <= lo) begin
        r.green = 8'd255;
      end else if (n <= hi) begin
        r.red = blend(n - lo, hi - lo);
        r.green = 8'd255;
      end else begin
        r.red = 8'd255;
        r.green = blend(100 - n, 100 - hi);
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  function automatic logic [15:0] pick_tvoc();
    int r, step, v;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      step = $urandom_range(0, 80);
      v = int'(walk_tvoc) + step - 40;
      if (v < 0) v = 0;
      if (v > 1000) v = 1000;
      walk_tvoc = 16'(v);
      return walk_tvoc;
    end
    if (r < 80) return 16'($urandom_range(0, 1000));
    if (r < 90) begin
      case ($urandom_range(0, 5))
        0: return 16'd0;
        1: return 16'd200;
        2: return 16'd201;
        3: return 16'd800;
        4: return 16'd801;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return $urandom;
    if (r < 50) return warm_len + $urandom_range(0, 5000);
    if (r < 80) return $urandom_range(0, warm_len);
    return warm_len - 1 + $urandom_range(0, 2);
  endfunction

  task automatic offer(sample_t s, bit known, result_t want);
    int      gap;
    result_t exp_r;
    gap = pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    exp_r = predict_led(s);
    color_queue.push_back(known ? want : exp_r);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_THRESHOLD_LOW:  thr_lo = val[6:0];
      CFG_THRESHOLD_HIGH: thr_hi = val[6:0];
      CFG_HYSTERESIS:     band = val[5:0];
      CFG_WARMUP_LEN:     warm_len = val;
      default: ;
    endcase
  endtask

  task automatic configure(int lo, int hi, int b, logic [31:0] w);
    while (color_queue.size() != 0) @(posedge clk);
    write_reg(CFG_THRESHOLD_LOW, 32'(lo));
    write_reg(CFG_THRESHOLD_HIGH, 32'(hi));
    write_reg(CFG_HYSTERESIS, 32'(b));
    write_reg(CFG_WARMUP_LEN, w);
    cfg_valid <= 1'b0;
  endtask

  // stimulus
  initial begin : source
    sample_t s;
    int      lo, hi, tmp;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      s.tvoc_level = directed[i].tvoc;
      s.time_ms = directed[i].tm;
      offer(s, directed[i].known, directed[i].want);
    end
    sample_valid <= 1'b0;

    for (int ph = 1; ph <= N_PHASES; ph++) begin
      case (ph)
        1: configure(0, 100, 0, 32'd0);
        2: configure(100, 100, 50, 32'hFFFF_FFFF);
        3: configure(100, 0, 50, 32'($urandom_range(0, 3000)));
        default: begin
          lo = $urandom_range(0, 100);
          hi = $urandom_range(0, 100);
          if (lo > hi && $urandom_range(0, 4) != 0) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
          end
          configure(lo, hi, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 50) :
                    $urandom_range(0, 12), 32'($urandom_range(0, 5000)));
        end
      endcase
      calm = (ph == 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        s.tvoc_level = pick_tvoc();
        s.time_ms = pick_time();
        offer(s, 1'b0, '0);
      end
      sample_valid <= 1'b0;
    end

    while (color_queue.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("tvoc_index_hysteresis_led_color verification clean");
    end else begin
      $display("tvoc_index_hysteresis_led_color verification failed");
    end
    $finish;
  end

  // result side, with one long hold-off to back the block up
  initial begin : sink
    int gap;
    bit held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = pick_gap();
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen <= results_seen + 1;
      if (color_queue.size() == 0) begin
        $error("result transfer with nothing pending: %h", result);
        failures <= failures + 1;
      end else begin
        want = color_queue.pop_front();
        if (result != want) failures <= failures + 1;
        if (result.air_index != want.air_index)
          $error("air_index expected %0d got %0d", want.air_index, result.air_index);
        if (result.red != want.red)
          $error("red expected %0d got %0d", want.red, result.red);
        if (result.green != want.green)
          $error("green expected %0d got %0d", want.green, result.green);
        if (result.blue != want.blue)
          $error("blue expected %0d got %0d", want.blue, result.blue);
        if (result.warming != want.warming)
          $error("warming expected %0d got %0d", want.warming, result.warming);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tvoc_index_hysteresis_led_color verification failed");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
